// ===== sv/arrt_pkg.sv =====
// Shared types, constants and helpers for the address range remap table.
// Used by arrt_table, arrt_front, arrt_back and address_range_remap_table.
package arrt_pkg;

  // Default slot count; the top level hands the real value down
  localparam int REGION_SLOTS_DEF = 16;

  // Address width and fan-in of one minimum-tree stage
  localparam int ADDR_W    = 32;
  localparam int MIN_FANIN = 8;

  typedef logic [ADDR_W-1:0] addr_t;

  // Distance reference when no region starts above a passthrough address
  localparam addr_t NO_NEXT_START = '1;

  // Action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_MAPPED   = 3'd0,
    ST_PASS     = 3'd1,
    ST_INSERTED = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_REJECT   = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  // One group of candidates for the next-region-start minimum
  typedef addr_t [MIN_FANIN-1:0] fanin_t;

  // Table write port
  typedef struct packed {
    logic  en;
    addr_t region_start;
    addr_t region_end;
    addr_t target_base;
  } tbl_wr_t;

  // Payload handed from the first stage to the result stage
  typedef struct packed {
    logic    action;
    status_t ins_status;
    logic    hit;
    addr_t   addr;
    addr_t   hit_start;
    addr_t   hit_end;
    addr_t   hit_target;
  } mid_t;

  // Balanced minimum over one fan-in group (three compare levels)
  function automatic addr_t min_fanin(input fanin_t v);
    addr_t w [MIN_FANIN];
    for (int k = 0; k < MIN_FANIN; k++) begin
      w[k] = v[k];
    end
    for (int s = 1; s < MIN_FANIN; s = s * 2) begin
      for (int k = 0; k + s < MIN_FANIN; k = k + 2 * s) begin
        if (w[k + s] < w[k]) begin
          w[k] = w[k + s];
        end
      end
    end
    return w[0];
  endfunction

endpackage

// ===== sv/arrt_table.sv =====
// Region storage: start, end and target per slot, valid marks and fill count.
// Depends on arrt_pkg. Slots fill in order, so the fill count is the free slot.
module arrt_table #(
  parameter int REGION_SLOTS = arrt_pkg::REGION_SLOTS_DEF,
  localparam int CNT_W = $clog2(REGION_SLOTS + 1),
  localparam int IDX_W = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  arrt_pkg::tbl_wr_t     wr,
  output logic [REGION_SLOTS-1:0] slot_valid,
  output arrt_pkg::addr_t       slot_start  [REGION_SLOTS],
  output arrt_pkg::addr_t       slot_end    [REGION_SLOTS],
  output arrt_pkg::addr_t       slot_target [REGION_SLOTS],
  output logic                  full
);

  logic [REGION_SLOTS-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  arrt_pkg::addr_t         start_r  [REGION_SLOTS];
  arrt_pkg::addr_t         end_r    [REGION_SLOTS];
  arrt_pkg::addr_t         target_r [REGION_SLOTS];

  // Next valid marks and count on a committed insert
  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    if (wr.en) begin
      valid_nxt[count_r[IDX_W-1:0]] = 1'b1;
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
  end

  // Entry payload, written at the free slot
  always_ff @(posedge clk) begin
    if (wr.en) begin
      start_r[count_r[IDX_W-1:0]]  <= wr.region_start;
      end_r[count_r[IDX_W-1:0]]    <= wr.region_end;
      target_r[count_r[IDX_W-1:0]] <= wr.target_base;
    end
  end

  assign slot_valid  = valid_r;
  assign slot_start  = start_r;
  assign slot_end    = end_r;
  assign slot_target = target_r;
  assign full        = (count_r == CNT_W'(REGION_SLOTS));

  // Valid marks track the fill count
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(count_r))
    else $error("valid marks disagree with fill count");

  // No write lands in a full table
  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> !full)
    else $error("insert committed into full table");

endmodule

// ===== sv/arrt_front.sv =====
// Input register and the single compute stage: per-slot compares, insert checks,
// hit select and group minima of next region starts. Depends on arrt_pkg.
module arrt_front #(
  parameter int REGION_SLOTS = arrt_pkg::REGION_SLOTS_DEF,
  localparam int NGROUP = (REGION_SLOTS + arrt_pkg::MIN_FANIN - 1) / arrt_pkg::MIN_FANIN
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_action,
  input  arrt_pkg::addr_t         in_region_start,
  input  arrt_pkg::addr_t         in_region_end,
  input  arrt_pkg::addr_t         in_target_base,
  input  arrt_pkg::addr_t         in_lookup_address,
  // table view
  input  logic [REGION_SLOTS-1:0] slot_valid,
  input  arrt_pkg::addr_t         slot_start  [REGION_SLOTS],
  input  arrt_pkg::addr_t         slot_end    [REGION_SLOTS],
  input  arrt_pkg::addr_t         slot_target [REGION_SLOTS],
  input  logic                    full,
  output arrt_pkg::tbl_wr_t       wr,
  // to result stage
  input  logic                    down_ready,
  output logic                    mid_valid,
  output arrt_pkg::mid_t          mid,
  output arrt_pkg::addr_t         grp_min [NGROUP]
);

  logic            s1_valid_r;
  logic            s1_action_r;
  arrt_pkg::addr_t s1_start_r, s1_end_r, s1_target_r, s1_addr_r;

  logic                    adv2;
  logic [REGION_SLOTS-1:0] hit_vec;
  logic [REGION_SLOTS-1:0] ovl_vec;
  arrt_pkg::fanin_t        cand [NGROUP];
  arrt_pkg::status_t       ins_status;

  // Stage advance: output register empty or being drained
  assign adv2     = down_ready;
  assign in_stall = s1_valid_r && !adv2;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_action_r <= in_action;
      s1_start_r  <= in_region_start;
      s1_end_r    <= in_region_end;
      s1_target_r <= in_target_base;
      s1_addr_r   <= in_lookup_address;
    end
  end

  // Per-slot compares and next-start candidates
  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      cand[g] = {arrt_pkg::MIN_FANIN{arrt_pkg::NO_NEXT_START}};
    end
    for (int i = 0; i < REGION_SLOTS; i++) begin
      hit_vec[i] = slot_valid[i] && (s1_addr_r >= slot_start[i]) &&
                   (s1_addr_r < slot_end[i]);
      ovl_vec[i] = slot_valid[i] && (slot_start[i] < s1_end_r) &&
                   (s1_start_r < slot_end[i]);
      if (slot_valid[i] && (slot_start[i] > s1_addr_r)) begin
        cand[i / arrt_pkg::MIN_FANIN][i % arrt_pkg::MIN_FANIN] = slot_start[i];
      end
    end
  end

  // Insert verdict: empty, inverted, overlap, then full
  always_comb begin
    if (s1_start_r == s1_end_r) begin
      ins_status = arrt_pkg::ST_EMPTY;
    end else if (s1_start_r > s1_end_r) begin
      ins_status = arrt_pkg::ST_REJECT;
    end else if (|ovl_vec) begin
      ins_status = arrt_pkg::ST_REJECT;
    end else if (full) begin
      ins_status = arrt_pkg::ST_FULL;
    end else begin
      ins_status = arrt_pkg::ST_INSERTED;
    end
  end

  // Hit select (regions never overlap, so at most one hit) and group minima
  always_comb begin
    mid            = '0;
    mid.action     = s1_action_r;
    mid.ins_status = ins_status;
    mid.hit        = |hit_vec;
    mid.addr       = s1_addr_r;
    for (int i = 0; i < REGION_SLOTS; i++) begin
      if (hit_vec[i]) begin
        mid.hit_start  = mid.hit_start  | slot_start[i];
        mid.hit_end    = mid.hit_end    | slot_end[i];
        mid.hit_target = mid.hit_target | slot_target[i];
      end
    end
    for (int g = 0; g < NGROUP; g++) begin
      grp_min[g] = arrt_pkg::min_fanin(cand[g]);
    end
  end

  // Insert commits as the transaction moves into the output register
  always_comb begin
    wr.en           = s1_valid_r && adv2 && (s1_action_r == arrt_pkg::ACT_INSERT) &&
                      (ins_status == arrt_pkg::ST_INSERTED);
    wr.region_start = s1_start_r;
    wr.region_end   = s1_end_r;
    wr.target_base  = s1_target_r;
  end

  assign mid_valid = s1_valid_r;

  // Stored regions stay disjoint: a lookup hits at most one slot
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $onehot0(hit_vec))
    else $error("address hits more than one region");

  // A held transaction stays in the input register
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv2 |=> s1_valid_r && $stable(s1_addr_r) && $stable(s1_action_r))
    else $error("input register lost a stalled transaction");

endmodule

// ===== sv/arrt_back.sv =====
// Result stage: final next-start minimum, address arithmetic, output register.
// Depends on arrt_pkg; fed by arrt_front.
module arrt_back #(
  parameter int REGION_SLOTS = arrt_pkg::REGION_SLOTS_DEF,
  localparam int NGROUP = (REGION_SLOTS + arrt_pkg::MIN_FANIN - 1) / arrt_pkg::MIN_FANIN
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            mid_valid,
  input  arrt_pkg::mid_t  mid,
  input  arrt_pkg::addr_t grp_min [NGROUP],
  output logic            down_ready,
  // result channel
  output logic            out_valid,
  input  logic            out_stall,
  output logic [2:0]      out_status,
  output arrt_pkg::addr_t out_translated_address,
  output arrt_pkg::addr_t out_span_left
);

  logic              out_valid_r;
  logic [2:0]        status_r, status_nxt;
  arrt_pkg::addr_t   xlat_r, xlat_nxt;
  arrt_pkg::addr_t   span_r, span_nxt;
  arrt_pkg::fanin_t  grp_pad;
  arrt_pkg::addr_t   next_start;

  assign down_ready = !out_valid_r || !out_stall;

  // Second level of the next-start minimum
  always_comb begin
    grp_pad = {arrt_pkg::MIN_FANIN{arrt_pkg::NO_NEXT_START}};
    for (int g = 0; g < NGROUP; g++) begin
      grp_pad[g] = grp_min[g];
    end
    next_start = arrt_pkg::min_fanin(grp_pad);
  end

  // Result fields
  always_comb begin
    if (mid.action == arrt_pkg::ACT_INSERT) begin
      status_nxt = mid.ins_status;
      xlat_nxt   = '0;
      span_nxt   = '0;
    end else if (mid.hit) begin
      status_nxt = arrt_pkg::ST_MAPPED;
      xlat_nxt   = mid.hit_target + (mid.addr - mid.hit_start);
      span_nxt   = mid.hit_end - mid.addr;
    end else begin
      status_nxt = arrt_pkg::ST_PASS;
      xlat_nxt   = mid.addr;
      span_nxt   = next_start - mid.addr;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (down_ready) begin
      out_valid_r <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (down_ready) begin
      status_r <= status_nxt;
      xlat_r   <= xlat_nxt;
      span_r   <= span_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = status_r;
  assign out_translated_address = xlat_r;
  assign out_span_left          = span_r;

endmodule

// ===== sv/address_range_remap_table.sv =====
// Address range remap table: stores up to REGION_SLOTS disjoint half-open
// regions [start, end) with a target base, and translates lookup addresses.
// Depends on arrt_pkg, arrt_table, arrt_front and arrt_back.
//
// A transaction accepted into the input register moves on into the output
// register once that register is empty or being drained, and its result is
// offered from the output register; with the result side never stalling, a new
// transaction is accepted every cycle. A held result stalls the input once the
// input register is occupied as well. All slots are compared in parallel
// between the two registers, where the minimum over next region starts is
// taken in groups of eight and then across groups, followed by the offset
// arithmetic. An insert is written into the table as it moves into the output
// register, so the very next transaction sees it. Slots fill in order and are
// never freed; the valid marks clear at reset, with no clearing pass. Status
// codes: 0 mapped, 1 passthrough, 2 inserted, 3 empty ignored, 4 overlap or
// inverted, 5 table full.
module address_range_remap_table #(
  parameter int REGION_SLOTS = arrt_pkg::REGION_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [31:0] in_region_start,
  input  logic [31:0] in_region_end,
  input  logic [31:0] in_target_base,
  input  logic [31:0] in_lookup_address,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_translated_address,
  output logic [31:0] out_span_left
);

  localparam int NGROUP =
    (REGION_SLOTS + arrt_pkg::MIN_FANIN - 1) / arrt_pkg::MIN_FANIN;

  logic [REGION_SLOTS-1:0] slot_valid;
  arrt_pkg::addr_t         slot_start  [REGION_SLOTS];
  arrt_pkg::addr_t         slot_end    [REGION_SLOTS];
  arrt_pkg::addr_t         slot_target [REGION_SLOTS];
  logic                    full;
  arrt_pkg::tbl_wr_t       wr;
  logic                    down_ready;
  logic                    mid_valid;
  arrt_pkg::mid_t          mid;
  arrt_pkg::addr_t         grp_min [NGROUP];

  // Region storage
  arrt_table #(.REGION_SLOTS(REGION_SLOTS)) u_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr          (wr),
    .slot_valid  (slot_valid),
    .slot_start  (slot_start),
    .slot_end    (slot_end),
    .slot_target (slot_target),
    .full        (full)
  );

  // Input register and compare logic
  arrt_front #(.REGION_SLOTS(REGION_SLOTS)) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_region_start   (in_region_start),
    .in_region_end     (in_region_end),
    .in_target_base    (in_target_base),
    .in_lookup_address (in_lookup_address),
    .slot_valid        (slot_valid),
    .slot_start        (slot_start),
    .slot_end          (slot_end),
    .slot_target       (slot_target),
    .full              (full),
    .wr                (wr),
    .down_ready        (down_ready),
    .mid_valid         (mid_valid),
    .mid               (mid),
    .grp_min           (grp_min)
  );

  // Result arithmetic and output register
  arrt_back #(.REGION_SLOTS(REGION_SLOTS)) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .mid_valid              (mid_valid),
    .mid                    (mid),
    .grp_min                (grp_min),
    .down_ready             (down_ready),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_status             (out_status),
    .out_translated_address (out_translated_address),
    .out_span_left          (out_span_left)
  );

endmodule

// ===== tb/address_range_remap_table_test.sv =====
`timescale 1ns / 1ps
// Testbench for address_range_remap_table: directed and random insert and lookup
// transactions, checked field by field against a behavioral copy of the region table.
// Depends on arrt_pkg and the address_range_remap_table RTL.
module address_range_remap_table_test;

  localparam int SLOTS = 16;

  typedef struct {
    arrt_pkg::status_t status;
    arrt_pkg::addr_t   xlat;
    arrt_pkg::addr_t   span;
  } remap_result_t;

  // DUT inputs, known from time zero
  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_action = arrt_pkg::ACT_INSERT;
  arrt_pkg::addr_t in_region_start = '0;
  arrt_pkg::addr_t in_region_end = '0;
  arrt_pkg::addr_t in_target_base = '0;
  arrt_pkg::addr_t in_lookup_address = '0;
  logic            out_stall = 1'b0;

  // DUT outputs
  logic        in_stall;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [31:0] out_translated_address;
  logic [31:0] out_span_left;

  address_range_remap_table #(
    .REGION_SLOTS(SLOTS)
  ) dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_action              (in_action),
    .in_region_start        (in_region_start),
    .in_region_end          (in_region_end),
    .in_target_base         (in_target_base),
    .in_lookup_address      (in_lookup_address),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_status             (out_status),
    .out_translated_address (out_translated_address),
    .out_span_left          (out_span_left)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the region table; slots fill in order and are never freed
  bit              shadow_valid [SLOTS];
  arrt_pkg::addr_t shadow_start [SLOTS];
  arrt_pkg::addr_t shadow_end [SLOTS];
  arrt_pkg::addr_t shadow_target [SLOTS];
  int              shadow_count = 0;

  remap_result_t pending_results [$];
  int            mismatch_count = 0;
  bit            sender_idle = 1'b1;
  bit            receiver_idle = 1'b1;
  bit            hold_active = 1'b0;

  // Idle length: mostly none or short, now and then long
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Translation of one address by the shadow table
  function automatic remap_result_t predict_lookup(arrt_pkg::addr_t a);
    remap_result_t   r;
    arrt_pkg::addr_t next;
    next = arrt_pkg::NO_NEXT_START;
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_valid[i]) begin
        if (a >= shadow_start[i] && a < shadow_end[i]) begin
          r.status = arrt_pkg::ST_MAPPED;
          r.xlat   = shadow_target[i] + (a - shadow_start[i]);
          r.span   = shadow_end[i] - a;
          return r;
        end
        if (shadow_start[i] > a && shadow_start[i] < next) next = shadow_start[i];
      end
    end
    r.status = arrt_pkg::ST_PASS;
    r.xlat   = a;
    r.span   = next - a;
    return r;
  endfunction

  // Insert into the shadow table; overlap is checked before a full table
  function automatic remap_result_t predict_insert(arrt_pkg::addr_t s, arrt_pkg::addr_t e,
                                                   arrt_pkg::addr_t t);
    remap_result_t r;
    int            free_slot;
    bit            overlap;
    free_slot = -1;
    overlap   = 1'b0;
    r.xlat    = '0;
    r.span    = '0;
    if (s == e) begin
      r.status = arrt_pkg::ST_EMPTY;
      return r;
    end
    if (s > e) begin
      r.status = arrt_pkg::ST_REJECT;
      return r;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_valid[i]) begin
        if (shadow_start[i] < e && s < shadow_end[i]) overlap = 1'b1;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (overlap) begin
      r.status = arrt_pkg::ST_REJECT;
    end else if (free_slot < 0) begin
      r.status = arrt_pkg::ST_FULL;
    end else begin
      shadow_valid[free_slot]  = 1'b1;
      shadow_start[free_slot]  = s;
      shadow_end[free_slot]    = e;
      shadow_target[free_slot] = t;
      shadow_count++;
      r.status = arrt_pkg::ST_INSERTED;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("%0t ns %s: expected %h, got %h", $time, what, want, got);
    mismatch_count++;
  endtask

  // Append one expected result to the scoreboard queue
  task automatic expect_result(remap_result_t r);
    pending_results = {pending_results, r};
  endtask

  // Offer one transaction, wait for acceptance, queue its expected result
  task automatic send_item(logic action, arrt_pkg::addr_t s, arrt_pkg::addr_t e,
                           arrt_pkg::addr_t t, arrt_pkg::addr_t a);
    int gap;
    in_valid          <= 1'b1;
    in_action         <= action;
    in_region_start   <= s;
    in_region_end     <= e;
    in_target_base    <= t;
    in_lookup_address <= a;
    do @(posedge clk); while (in_stall);
    if (action == arrt_pkg::ACT_INSERT) expect_result(predict_insert(s, e, t));
    else expect_result(predict_lookup(a));
    gap = sender_idle ? idle_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_insert(arrt_pkg::addr_t s, arrt_pkg::addr_t e, arrt_pkg::addr_t t);
    send_item(arrt_pkg::ACT_INSERT, s, e, t, $urandom);
  endtask

  task automatic send_lookup(arrt_pkg::addr_t a);
    send_item(arrt_pkg::ACT_LOOKUP, $urandom, $urandom, $urandom, a);
  endtask

  // Sender pauses until every expected result has arrived
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Insert a region in a free gap of the table, else one address at the last try
  task automatic insert_free_region();
    remap_result_t   p;
    arrt_pkg::addr_t a;
    arrt_pkg::addr_t len;
    for (int tries = 0; tries < 16; tries++) begin
      a = $urandom;
      p = predict_lookup(a);
      if (p.status == arrt_pkg::ST_PASS && p.span != 0) break;
    end
    if (p.status != arrt_pkg::ST_PASS || p.span == 0) begin
      send_insert(a, a + 1, $urandom);
    end else begin
      if ($urandom_range(0, 3) == 0) len = $urandom_range(1, p.span);
      else len = $urandom_range(1, (p.span < 4096) ? p.span : 4096);
      send_insert(a, a + len, $urandom);
    end
  endtask

  // Empty, inverted, overlapping or fully random insert
  task automatic insert_bad_region();
    arrt_pkg::addr_t s;
    arrt_pkg::addr_t e;
    int              k;
    s = $urandom;
    e = $urandom;
    case ($urandom_range(0, 3))
      0: e = s;
      1: begin
        if (s == 0) s = 1;
        e = $urandom_range(0, s - 1);
      end
      2: begin
        if (shadow_count > 0) begin
          k = $urandom_range(0, shadow_count - 1);
          s = shadow_start[k] + $urandom_range(0, shadow_end[k] - shadow_start[k] - 1);
          e = s + $urandom_range(1, 4096);
        end
      end
      default: ;
    endcase
    send_insert(s, e, $urandom);
  endtask

  // Lookup address, mostly on or next to a stored region boundary
  function automatic arrt_pkg::addr_t boundary_address();
    int k;
    if (shadow_count == 0 || $urandom_range(0, 99) < 25) return $urandom;
    k = $urandom_range(0, shadow_count - 1);
    case ($urandom_range(0, 4))
      0: return shadow_start[k];
      1: return shadow_start[k] - 1;
      2: return shadow_end[k] - 1;
      3: return shadow_end[k];
      default: return shadow_start[k] +
                      $urandom_range(0, shadow_end[k] - shadow_start[k] - 1);
    endcase
  endfunction

  // Result checking and receiver stall pattern
  always @(posedge clk) begin : result_check
    remap_result_t want;
    int            stall_left;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected, status", '0, out_status);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) report_mismatch("status", want.status, out_status);
        if (out_translated_address !== want.xlat)
          report_mismatch("translated_address", want.xlat, out_translated_address);
        if (out_span_left !== want.span) report_mismatch("span_left", want.span, out_span_left);
      end
    end
    // long hold-off while requested, else random stall runs
    if (hold_active) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      stall_left = receiver_idle ? idle_length() : 0;
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Lookups on an empty table pass through
  task automatic test_empty_table();
    send_lookup(32'h0000_0000);
    send_lookup(32'hFFFF_FFFF);
  endtask

  // Empty, inverted, touching and overlapping inserts
  task automatic test_insert_rules();
    send_insert(32'h0000_0100, 32'h0000_0100, 32'h0000_1111);
    send_insert(32'h0000_0200, 32'h0000_0100, 32'h0000_2222);
    send_insert(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    send_insert(32'h0000_1000, 32'h0000_2000, 32'hFFFF_F800);
    send_insert(32'h0000_2000, 32'h0000_3000, 32'h0000_0000);
    send_insert(32'h0000_0800, 32'h0000_1000, 32'hFFFF_FFFF);
    send_insert(32'h0000_1FFF, 32'h0000_2001, 32'h0000_4444);
    send_insert(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_5555);
    send_insert(32'h0000_2800, 32'h0000_2801, 32'h0000_6666);
    send_insert(32'hFFFF_FF00, 32'hFFFF_FFFF, 32'h1234_0000);
    send_insert(32'h0000_0000, 32'h0000_0001, 32'h0000_0005);
  endtask

  // Region edges, target wrap and the top of the address space
  task automatic test_lookup_edges();
    send_lookup(32'h0000_0000);
    send_lookup(32'h0000_0001);
    send_lookup(32'h0000_1000);
    send_lookup(32'h0000_17FF);
    send_lookup(32'h0000_1800);
    send_lookup(32'h0000_1FFF);
    send_lookup(32'h0000_2000);
    send_lookup(32'h0000_3000);
    send_lookup(32'hFFFF_FEFF);
    send_lookup(32'hFFFF_FF00);
    send_lookup(32'hFFFF_FFFE);
    send_lookup(32'hFFFF_FFFF);
  endtask

  // Mixed traffic; idling switches on and off in stretches
  task automatic test_random_traffic(int count);
    int r;
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) begin
        sender_idle   = ($urandom_range(0, 3) != 0);
        receiver_idle = ($urandom_range(0, 3) != 0);
      end
      r = $urandom_range(0, 99);
      if (r < 12) insert_free_region();
      else if (r < 17) insert_bad_region();
      else send_lookup(boundary_address());
    end
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
  endtask

  // Fill every slot, then full, overlap-before-full, empty and inverted inserts
  task automatic test_full_table();
    for (int tries = 0; tries < 400 && shadow_count < SLOTS; tries++) insert_free_region();
    insert_free_region();
    send_insert(shadow_start[0], shadow_end[0], $urandom);
    send_insert(32'h0000_0100, 32'h0000_0100, $urandom);
    send_insert(32'h8000_0000, 32'h7FFF_FFFF, $urandom);
  endtask

  // Receiver holds off while the sender keeps offering, then the sender pauses
  task automatic test_backpressure();
    wait_for_results();
    sender_idle = 1'b0;
    fork
      begin
        // long receiver hold-off, counted in cycles
        hold_active = 1'b1;
        repeat (64) @(posedge clk);
        hold_active = 1'b0;
      end
      begin
        for (int n = 0; n < 30; n++) send_lookup(boundary_address());
      end
    join
    wait_for_results();
    sender_idle = 1'b1;
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_insert_rules();
    test_lookup_edges();
    test_random_traffic(260);
    test_full_table();
    test_backpressure();
    test_random_traffic(120);
    wait_for_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("address_range_remap_table: match");
    end else begin
      $display("address_range_remap_table: mismatch");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("address_range_remap_table: mismatch");
    $finish;
  end

endmodule
